// ===== rtl/crpr_pkg.sv =====
// crpr_pkg: shared types, constants and helper functions for the capture ram to pcap
// record formatter; no dependencies
`timescale 1ns / 1ps
package crpr_pkg;
    localparam int MAX_PACKET_BYTES = 10000;
    localparam int RECORD_BYTES     = 64;
    localparam int RW_RAW           = RECORD_BYTES / 8;
    localparam int RECORD_WORDS     = (RW_RAW == 0) ? 1 : RW_RAW;
    localparam int LEN_W            = 16;
    localparam int CNT_W            = 16;
    localparam logic [63:0] SIG_WORD = 64'h00666C6F57202E44;
    localparam logic [63:0] END_WORD = 64'hDEADBEEFDEADBEEF;
    localparam logic [31:0] NS_PER_S = 32'd1000000000;
    localparam logic [CNT_W-1:0] HDR_WORDS = CNT_W'(8);

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_SENTINEL = 3'd1,
        ST_BAD_SIG  = 3'd2,
        ST_BAD_LEN  = 3'd3,
        ST_LIMIT    = 3'd4
    } t_status;

    typedef enum logic [2:0] {
        S_HDR, S_DIV, S_OUT_TS, S_OUT_LEN, S_DATA, S_PAD, S_STAT, S_DONE
    } t_state;

    typedef enum logic [0:0] {
        CFG_FREQ  = 1'b0,
        CFG_LIMIT = 1'b1
    } t_cfg_index;

    // controller to datapath
    typedef struct packed {
        logic    clear;      // first word: clear counters
        logic    cnt_inc;
        logic    cnt_clr;
        logic    cap_ts;
        logic    cap_len;
        logic    div_start;
        logic    load_out;
        logic [1:0] out_sel; // 0 ts, 1 len, 2 data, 3 status
        t_status st;
        logic    inc_written;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic             limit_hit;
        logic             len_bad;
        logic             last_data;
        logic             pad_done;
        logic             div_busy;
    } t_stat;
endpackage

// ===== rtl/crpr_divider.sv =====
// crpr_divider: restoring divider, one quotient bit a cycle, 96-bit dividend by 32 bits
// depends on crpr_pkg
`timescale 1ns / 1ps
module crpr_divider (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [95:0] i_num,
    input  logic [31:0] i_den,
    output logic        o_busy,
    output logic [95:0] o_quot,
    output logic [31:0] o_rem
);
    import crpr_pkg::*;
    logic [95:0] r_q, n_q;
    logic [32:0] r_r, n_r;
    logic [31:0] r_d;
    logic [6:0]  r_cnt, n_cnt;
    logic [32:0] w_sh;

    always_comb begin
        w_sh  = {r_r[31:0], r_q[95]};
        n_q   = {r_q[94:0], 1'b0};
        n_r   = w_sh;
        n_cnt = r_cnt - 7'd1;
        if (w_sh >= {1'b0, r_d}) begin
            n_r     = w_sh - {1'b0, r_d};
            n_q[0]  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= 7'd96;
        end else if (r_cnt != 7'd0) begin
            r_cnt <= n_cnt;
        end
        if (i_start) begin
            r_q <= i_num;
            r_r <= '0;
            r_d <= i_den;
        end else if (r_cnt != 7'd0) begin
            r_q <= n_q;
            r_r <= n_r;
        end
    end

    assign o_busy = i_start || (r_cnt != 7'd0);
    assign o_quot = r_q;
    assign o_rem  = r_r[31:0];
endmodule

// ===== rtl/crpr_datapath.sv =====
// crpr_datapath: counters, captured header fields, timestamp conversion and output word
// depends on crpr_pkg and crpr_divider
`timescale 1ns / 1ps
module crpr_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  crpr_pkg::t_cmd     i_cmd,
    input  logic [63:0]        i_word,
    input  logic [31:0]        i_freq,
    input  logic [31:0]        i_limit,
    output crpr_pkg::t_stat    o_stat,
    output logic [63:0]        o_out_word,
    output logic [3:0]         o_out_bytes,
    output logic               o_record_end,
    output logic [2:0]         o_status,
    output logic [31:0]        o_packets_done
);
    import crpr_pkg::*;
    logic [CNT_W-1:0] r_cnt;
    logic [LEN_W-1:0] r_len;
    logic [63:0]      r_ts;
    logic [31:0]      r_written;
    logic [1:0]       r_phase;     // 0 div secs, 1 scale remainder, 2 div nanos, 3 finish
    logic             r_run;
    logic [63:0]      r_plo;
    logic             r_dstart;
    logic [95:0]      r_dnum;
    logic [31:0]      r_dden;
    logic [31:0]      r_secs, r_nanos;
    logic             d_busy;
    logic [95:0]      d_quot;
    logic [31:0]      d_rem;
    logic [CNT_W+3:0] w_next_off;
    logic [CNT_W+3:0] w_off;
    logic [CNT_W+3:0] w_rem;
    logic [3:0]       w_n;
    logic [63:0]      w_mask;
    logic [LEN_W:0]   w_recs;
    logic [LEN_W+8:0] w_padw;

    crpr_divider u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_dstart), .i_num(r_dnum),
        .i_den(r_dden), .o_busy(d_busy), .o_quot(d_quot), .o_rem(d_rem)
    );

    always_comb begin
        w_off      = (CNT_W+4)'({r_cnt, 3'b000});
        w_next_off = w_off + (CNT_W+4)'(8);
        w_rem      = (CNT_W+4)'(r_len) - w_off;
        w_n        = (w_rem > (CNT_W+4)'(8)) ? 4'd8 : w_rem[3:0];
        w_mask     = (w_n >= 4'd8) ? {64{1'b1}} : ((64'd1 << {w_n[2:0], 3'b000}) - 64'd1);
        w_recs     = (LEN_W+1)'((32'(r_len) + RECORD_BYTES - 1) / RECORD_BYTES);
        w_padw     = (LEN_W+9)'(w_recs) * (LEN_W+9)'(RECORD_WORDS);
    end

    assign o_stat.cnt       = r_cnt;
    // a first word clears the packet count before the limit is checked
    assign o_stat.limit_hit = ((i_cmd.clear ? 32'd0 : r_written) >= i_limit);
    assign o_stat.len_bad   = (i_word[15:0] == 16'd0) ||
                              (i_word[15:0] >= 16'(MAX_PACKET_BYTES));
    assign o_stat.last_data = (w_next_off >= (CNT_W+4)'(r_len));
    assign o_stat.pad_done  = ((LEN_W+9)'(r_cnt) + (LEN_W+9)'(1)) >= w_padw;
    assign o_stat.div_busy  = r_run || r_dstart || d_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0; r_len <= '0; r_ts <= '0; r_written <= '0;
            r_run <= 1'b0; r_dstart <= 1'b0; r_phase <= '0;
        end else begin
            r_dstart <= 1'b0;
            if (i_cmd.clear) begin
                r_cnt <= '0; r_len <= '0; r_ts <= '0; r_written <= '0;
            end
            if (i_cmd.cnt_clr) r_cnt <= '0;
            else if (i_cmd.cnt_inc) r_cnt <= (i_cmd.clear ? CNT_W'(0) : r_cnt) + CNT_W'(1);
            if (i_cmd.cap_ts) r_ts <= i_word;
            if (i_cmd.cap_len) r_len <= i_word[15:0];
            if (i_cmd.inc_written) r_written <= r_written + 32'd1;
            if (i_cmd.div_start) begin
                r_run <= 1'b1; r_phase <= 2'd0;
            end else if (r_run && !d_busy && !r_dstart) begin
                case (r_phase)
                    2'd0: begin
                        // whole seconds and leftover clocks
                        r_dstart <= 1'b1;
                        r_dnum   <= {32'd0, r_ts};
                        r_dden   <= (i_freq == 32'd0) ? 32'd1 : i_freq;
                        r_phase  <= 2'd1;
                    end
                    2'd1: begin
                        r_secs  <= d_quot[31:0];
                        r_plo   <= d_rem * NS_PER_S;
                        r_phase <= 2'd2;
                    end
                    2'd2: begin
                        // leftover clocks scaled to nanoseconds
                        r_dstart <= 1'b1;
                        r_dnum   <= {32'd0, r_plo};
                        r_phase  <= 2'd3;
                    end
                    default: begin
                        r_nanos <= d_quot[31:0];
                        r_run   <= 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            o_packets_done <= r_written + (i_cmd.inc_written ? 32'd1 : 32'd0);
            case (i_cmd.out_sel)
                2'd0: begin
                    o_out_word <= {r_nanos, r_secs}; o_out_bytes <= 4'd8;
                    o_record_end <= 1'b0; o_status <= ST_OK;
                end
                2'd1: begin
                    o_out_word <= {16'd0, r_len, 16'd0, r_len}; o_out_bytes <= 4'd8;
                    o_record_end <= 1'b0; o_status <= ST_OK;
                end
                2'd2: begin
                    o_out_word <= i_word & w_mask; o_out_bytes <= w_n;
                    o_record_end <= o_stat.last_data; o_status <= ST_OK;
                end
                default: begin
                    o_out_word <= '0; o_out_bytes <= 4'd0;
                    o_record_end <= 1'b0; o_status <= i_cmd.st;
                    o_packets_done <= i_cmd.clear ? 32'd0 : r_written;
                end
            endcase
        end
    end
endmodule

// ===== rtl/crpr_ctrl.sv =====
// crpr_ctrl: sequencer for header, conversion, data and padding phases, and handshakes
// depends on crpr_pkg
`timescale 1ns / 1ps
module crpr_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_first,
    input  logic [63:0]     i_word,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  crpr_pkg::t_stat i_stat,
    output crpr_pkg::t_cmd  o_cmd
);
    import crpr_pkg::*;
    t_state r_state, n_state;
    logic   r_ov, n_ov;
    logic   w_acc, w_free;
    t_state w_st;
    logic [CNT_W-1:0] w_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_HDR; r_ov <= 1'b0;
        end else begin
            r_state <= n_state; r_ov <= n_ov;
        end
    end

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        w_free  = !r_ov || i_out_ready;
        n_ov    = r_ov && !i_out_ready;
        o_in_ready = 1'b0;
        w_st    = r_state;
        w_cnt   = i_stat.cnt;
        case (r_state)
            S_HDR, S_DATA, S_PAD, S_DONE: o_in_ready = w_free;
            default: o_in_ready = 1'b0;
        endcase
        w_acc = i_in_valid && o_in_ready;
        if (w_acc && i_first) begin
            o_cmd.clear = 1'b1; w_st = S_HDR; w_cnt = '0;
        end
        case (r_state)
            S_DIV: if (!i_stat.div_busy) n_state = S_OUT_TS;
            S_OUT_TS: if (w_free) begin
                o_cmd.load_out = 1'b1; o_cmd.out_sel = 2'd0; n_ov = 1'b1;
                n_state = S_OUT_LEN;
            end
            S_OUT_LEN: if (w_free) begin
                o_cmd.load_out = 1'b1; o_cmd.out_sel = 2'd1; n_ov = 1'b1;
                n_state = S_HDR;
            end
            default: ;
        endcase
        if (w_acc) begin
            case (w_st)
                S_HDR: begin
                    if (w_cnt + CNT_W'(1) >= HDR_WORDS) begin
                        o_cmd.cnt_clr = 1'b1; n_state = S_DATA;
                    end else begin
                        o_cmd.cnt_inc = 1'b1; n_state = S_HDR;
                    end
                    if (w_cnt == CNT_W'(0)) begin
                        o_cmd.st = ST_OK;
                        if (i_stat.limit_hit) o_cmd.st = ST_LIMIT;
                        else if (i_word == END_WORD) o_cmd.st = ST_SENTINEL;
                        else if (i_word != SIG_WORD) o_cmd.st = ST_BAD_SIG;
                        if (o_cmd.st != ST_OK) begin
                            o_cmd.load_out = 1'b1; o_cmd.out_sel = 2'd3; n_ov = 1'b1;
                            n_state = S_DONE;
                        end
                    end else if (w_cnt == CNT_W'(1)) begin
                        o_cmd.cap_ts = 1'b1;
                    end else if (w_cnt == CNT_W'(2)) begin
                        if (i_stat.len_bad) begin
                            o_cmd.st = ST_BAD_LEN;
                            o_cmd.load_out = 1'b1; o_cmd.out_sel = 2'd3; n_ov = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            o_cmd.cap_len = 1'b1; o_cmd.div_start = 1'b1;
                            n_state = S_DIV;
                        end
                    end
                end
                S_DATA: begin
                    o_cmd.load_out = 1'b1; o_cmd.out_sel = 2'd2; n_ov = 1'b1;
                    o_cmd.cnt_inc = 1'b1;
                    if (i_stat.last_data) begin
                        o_cmd.inc_written = 1'b1;
                        if (i_stat.pad_done) begin
                            o_cmd.cnt_inc = 1'b0; o_cmd.cnt_clr = 1'b1; n_state = S_HDR;
                        end else n_state = S_PAD;
                    end
                end
                S_PAD: begin
                    o_cmd.cnt_inc = 1'b1;
                    if (i_stat.pad_done) begin
                        o_cmd.cnt_inc = 1'b0; o_cmd.cnt_clr = 1'b1; n_state = S_HDR;
                    end
                end
                default: n_state = S_DONE;
            endcase
        end
    end

    assign o_out_valid = r_ov;
endmodule

// ===== rtl/capture_ram_to_pcap_records.sv =====
// capture_ram_to_pcap_records: top level, joins controller and datapath and holds the
// configuration registers; depends on crpr_pkg, crpr_ctrl, crpr_datapath
`timescale 1ns / 1ps
// usage
// - s_axis carries capture memory words: tdata = ram_word, tuser = first_word
// - m_axis carries pcap words: tdata = out_word, tuser = out_bytes, status,
//   packets_done; tlast = record_end (last data word of a packet)
// - cfg channel writes clock_frequency_hz (index 0) and packet_limit (index 1)
// - header word 2, after words 0 and 1, starts the timestamp conversion:
//   a 96-step bit-serial division of the clock count by the frequency, one
//   multiply of the remainder by 10^9, then a second 96-step division by the
//   frequency, after which the two record header words go out one a cycle
//   while the receiver does not stall; words 3 to 7 then follow
// - data and padding words are both read from the input, one output word per data word
// - the single output register lets a new input word in while the last
//   result is taken; when the receiver stalls the input stalls too
// - reset (synchronous, active low) returns to header word zero, clears the
//   counters and loads the default frequency and limit
// - after a status word nothing comes out until a word with first_word set
module capture_ram_to_pcap_records (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // ram_word
    input  logic        s_axis_tuser,   // first_word
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // out_word
    output logic [38:0] m_axis_tuser,   // out_bytes[3:0], status[6:4], packets_done[38:7]
    output logic        m_axis_tlast,   // record_end
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import crpr_pkg::*;
    logic [31:0] r_freq, r_limit;
    t_cmd  w_cmd;
    t_stat w_stat;
    logic [3:0]  w_bytes;
    logic [2:0]  w_status;
    logic [31:0] w_done;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= 32'd100000000; r_limit <= 32'hFFFFFFFF;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_FREQ:  r_freq  <= i_cfg_data;
                CFG_LIMIT: r_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    crpr_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(s_axis_tvalid),
        .o_in_ready(s_axis_tready), .i_first(s_axis_tuser), .i_word(s_axis_tdata),
        .o_out_valid(m_axis_tvalid), .i_out_ready(m_axis_tready),
        .i_stat(w_stat), .o_cmd(w_cmd)
    );

    crpr_datapath u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .i_word(s_axis_tdata),
        .i_freq(r_freq), .i_limit(r_limit), .o_stat(w_stat),
        .o_out_word(m_axis_tdata), .o_out_bytes(w_bytes), .o_record_end(m_axis_tlast),
        .o_status(w_status), .o_packets_done(w_done)
    );

    assign m_axis_tuser = {w_done, w_status, w_bytes};
endmodule

// ===== rtl/crpr_checker.sv =====
// crpr_checker: port-level assertions for the formatter, bound to the top level
// depends on crpr_pkg
`timescale 1ns / 1ps
module crpr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic [38:0] m_axis_tuser,
    input logic        m_axis_tlast
);
    import crpr_pkg::*;
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
        else $error("stalled word changed");
    a_status_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[6:4] != 3'd0 |-> m_axis_tuser[3:0] == 4'd0
        && m_axis_tdata == 64'd0 && !m_axis_tlast)
        else $error("status word carries data");
    a_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[6:4] == 3'd0 |-> m_axis_tuser[3:0] != 4'd0
        && m_axis_tuser[3:0] <= 4'd8)
        else $error("bad byte count");
endmodule

bind capture_ram_to_pcap_records crpr_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata),
    .m_axis_tuser(m_axis_tuser), .m_axis_tlast(m_axis_tlast)
);
